// ===== rtl/ibwa_pkg.sv =====
// Package for the backward warp address generator: widths, register indexes,
// reset values and the divider stage record. No dependencies.
`default_nettype none
package ibwa_pkg;

    localparam int COEF_W   = 40;
    localparam int NUM_REGS = 8;
    localparam int IDX_W    = 3;
    localparam int PROD_W   = 50;
    localparam int MAG_W    = 52;
    localparam int QMAX     = 13;
    localparam int IN_W     = 9;
    localparam int ADDR_W   = 11;

    localparam int OUT_DIM_DEF    = 512;
    localparam int SRC_WIDTH_DEF  = 2048;
    localparam int SRC_HEIGHT_DEF = 2048;

    localparam logic [IDX_W-1:0] REG_U_COL   = 3'd0;
    localparam logic [IDX_W-1:0] REG_U_ROW   = 3'd1;
    localparam logic [IDX_W-1:0] REG_U_CONST = 3'd2;
    localparam logic [IDX_W-1:0] REG_V_COL   = 3'd3;
    localparam logic [IDX_W-1:0] REG_V_ROW   = 3'd4;
    localparam logic [IDX_W-1:0] REG_V_CONST = 3'd5;
    localparam logic [IDX_W-1:0] REG_W_COL   = 3'd6;
    localparam logic [IDX_W-1:0] REG_W_ROW   = 3'd7;

    localparam logic [COEF_W-1:0] ONE_Q16 = 40'd65536;

    typedef struct packed {
        logic [MAG_W-1:0] dmag;
        logic [MAG_W-1:0] rem_u;
        logic [MAG_W-1:0] rem_v;
        logic [QMAX-1:0]  q_u;
        logic [QMAX-1:0]  q_v;
        logic             neg_u;
        logic             neg_v;
        logic             bad;
    } div_t;

    function automatic logic [COEF_W-1:0] reg_reset(input logic [IDX_W-1:0] idx);
        logic [COEF_W-1:0] r;
        case (idx)
            REG_U_COL: r = ONE_Q16;
            REG_V_ROW: r = ONE_Q16;
            default:   r = '0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/ipm_backward_warp_address.sv =====
// Top level of the backward warp address generator: multiply, sum, sign
// split and a restoring divider of one quotient bit per stage. Uses ibwa_pkg.
//
// Usage: each beat on s_axis carries one output map pixel (column, row); one
// beat leaves on m_axis with the source column and row to sample and a valid
// flag in tuser. Addresses are zero when the flag is low (zero denominator,
// pixel outside the map or a source point outside the source image).
// The user writes coefficients on the cfg port only while the block is idle; the block does not enforce it.
// Pipeline: product and sum registers, a magnitude and sign register, the
// divider chain, one compare and subtract stage per quotient bit over the bit
// count QB of the larger source dimension (11 at 2048), then the output register.
// Throughput: one beat per cycle. All stages advance together; when the
// receiver holds m_tready low with a beat waiting, the whole pipe holds and
// s_tready drops, so nothing is lost or repeated.
// Reset: clears all stage valid bits and loads the coefficients with the
// identity mapping (unit column and row coefficients, all else zero).
`default_nettype none
module ipm_backward_warp_address #(
    parameter int OUT_DIM    = ibwa_pkg::OUT_DIM_DEF,
    parameter int SRC_WIDTH  = ibwa_pkg::SRC_WIDTH_DEF,
    parameter int SRC_HEIGHT = ibwa_pkg::SRC_HEIGHT_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [ibwa_pkg::IDX_W-1:0]   cfg_addr,
    input  wire logic [ibwa_pkg::COEF_W-1:0]  cfg_wdata,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [23:0]                  s_tdata,   // out_col[8:0], out_row[17:9]
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [23:0]                       m_tdata,   // src_col[10:0], src_row[21:11]
    output logic                              m_tuser    // src_valid
);
    import ibwa_pkg::*;

    localparam int SRC_MAX = (SRC_WIDTH > SRC_HEIGHT) ? SRC_WIDTH : SRC_HEIGHT;
    localparam int QB      = $clog2(SRC_MAX);
    localparam int WIDE_W  = MAG_W + QMAX;

    logic [COEF_W-1:0] h_reg [NUM_REGS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                h_reg[i] <= reg_reset(IDX_W'(i));
            end
        end
        else if (cfg_we)
        begin
            h_reg[cfg_addr] <= cfg_wdata;
        end
    end

    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // stage 1: products
    logic [IN_W-1:0] col_in;
    logic [IN_W-1:0] row_in;
    assign col_in = s_tdata[IN_W-1:0];
    assign row_in = s_tdata[2*IN_W-1:IN_W];

    logic              v1_reg;
    logic signed [PROD_W-1:0] p_uc_reg, p_ur_reg, p_vc_reg, p_vr_reg, p_wc_reg, p_wr_reg;
    logic signed [COEF_W-1:0] k_u_reg, k_v_reg;
    logic              oob1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_uc_reg <= $signed(h_reg[REG_U_COL]) * $signed({1'b0, col_in});
            p_ur_reg <= $signed(h_reg[REG_U_ROW]) * $signed({1'b0, row_in});
            p_vc_reg <= $signed(h_reg[REG_V_COL]) * $signed({1'b0, col_in});
            p_vr_reg <= $signed(h_reg[REG_V_ROW]) * $signed({1'b0, row_in});
            p_wc_reg <= $signed(h_reg[REG_W_COL]) * $signed({1'b0, col_in});
            p_wr_reg <= $signed(h_reg[REG_W_ROW]) * $signed({1'b0, row_in});
            k_u_reg  <= $signed(h_reg[REG_U_CONST]);
            k_v_reg  <= $signed(h_reg[REG_V_CONST]);
            oob1_reg <= (32'(col_in) >= OUT_DIM) || (32'(row_in) >= OUT_DIM);
        end
    end

    // stage 2: sums
    logic                    v2_reg;
    logic signed [MAG_W-1:0] u_reg, vv_reg, w_reg;
    logic                    oob2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_reg    <= MAG_W'(p_uc_reg) + MAG_W'(p_ur_reg) + MAG_W'(k_u_reg);
            vv_reg   <= MAG_W'(p_vc_reg) + MAG_W'(p_vr_reg) + MAG_W'(k_v_reg);
            w_reg    <= MAG_W'(p_wc_reg) + MAG_W'(p_wr_reg) + MAG_W'(ONE_Q16);
            oob2_reg <= oob1_reg;
        end
    end

    // stage 3: magnitudes, signs, range precheck
    logic [MAG_W-1:0] umag, vmag, wmag;
    logic [WIDE_W-1:0] wlim;
    div_t dv_reg  [QB+1];
    div_t dv_next [QB+1];
    logic dvv_reg [QB+1];

    always_comb
    begin
        umag = u_reg[MAG_W-1]  ? MAG_W'(-u_reg)  : MAG_W'(u_reg);
        vmag = vv_reg[MAG_W-1] ? MAG_W'(-vv_reg) : MAG_W'(vv_reg);
        wmag = w_reg[MAG_W-1]  ? MAG_W'(-w_reg)  : MAG_W'(w_reg);
        wlim = WIDE_W'(wmag) << QB;
        dv_next[0].dmag  = wmag;
        dv_next[0].rem_u = umag;
        dv_next[0].rem_v = vmag;
        dv_next[0].q_u   = '0;
        dv_next[0].q_v   = '0;
        dv_next[0].neg_u = u_reg[MAG_W-1] ^ w_reg[MAG_W-1];
        dv_next[0].neg_v = vv_reg[MAG_W-1] ^ w_reg[MAG_W-1];
        dv_next[0].bad   = oob2_reg || (wmag == '0) ||
                           (WIDE_W'(umag) >= wlim) || (WIDE_W'(vmag) >= wlim);
    end

    generate
        for (genvar k = 0; k < QB; k++)
        begin : g_div
            localparam int B = QB - 1 - k;
            logic [WIDE_W-1:0] dsh;
            always_comb
            begin
                dsh = WIDE_W'(dv_reg[k].dmag) << B;
                dv_next[k+1] = dv_reg[k];
                if (WIDE_W'(dv_reg[k].rem_u) >= dsh)
                begin
                    dv_next[k+1].rem_u = dv_reg[k].rem_u - MAG_W'(dsh);
                    dv_next[k+1].q_u[B] = 1'b1;
                end
                if (WIDE_W'(dv_reg[k].rem_v) >= dsh)
                begin
                    dv_next[k+1].rem_v = dv_reg[k].rem_v - MAG_W'(dsh);
                    dv_next[k+1].q_v[B] = 1'b1;
                end
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= QB; i++)
            begin
                dvv_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            dvv_reg[0] <= v2_reg;
            for (int i = 1; i <= QB; i++)
            begin
                dvv_reg[i] <= dvv_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i <= QB; i++)
            begin
                dv_reg[i] <= dv_next[i];
            end
        end
    end

    // output stage
    div_t fin;
    logic ok;
    assign fin = dv_reg[QB];
    assign ok  = !fin.bad &&
                 (32'(fin.q_u) < SRC_WIDTH) && (32'(fin.q_v) < SRC_HEIGHT) &&
                 (!fin.neg_u || fin.q_u == '0) && (!fin.neg_v || fin.q_v == '0);

    logic              out_valid_reg;
    logic [ADDR_W-1:0] col_reg, row_reg;
    logic              flag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= dvv_reg[QB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            col_reg  <= ok ? ADDR_W'(fin.q_u) : '0;
            row_reg  <= ok ? ADDR_W'(fin.q_v) : '0;
            flag_reg <= ok;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, row_reg, col_reg};
    assign m_tuser  = flag_reg;

    a_zero_when_invalid : assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("address nonzero on invalid beat");

    a_col_in_range : assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (32'(m_tdata[10:0]) < SRC_WIDTH || SRC_WIDTH > 2048))
        else $error("source column outside image");

    a_ready_tracks_out : assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready out of step with output stage");

    a_hold_on_stall : assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("output beat changed while stalled");

endmodule
`default_nettype wire
